// ----- hw/rtl/hrdp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package hrdp_pkg;

	localparam logic [7:0] LONG_PREFIX = 8'hFE;

	localparam logic [1:0] ITEM_MAIN   = 2'd0;
	localparam logic [1:0] ITEM_GLOBAL = 2'd1;
	localparam logic [1:0] ITEM_LOCAL  = 2'd2;

	localparam logic [3:0] TAG_INPUT      = 4'd8;
	localparam logic [3:0] TAG_OUTPUT     = 4'd9;
	localparam logic [3:0] TAG_COLLECTION = 4'd10;
	localparam logic [3:0] TAG_FEATURE    = 4'd11;
	localparam logic [3:0] TAG_END_COLL   = 4'd12;

	localparam logic [3:0] TAG_USAGE_PAGE   = 4'd0;
	localparam logic [3:0] TAG_REPORT_SIZE  = 4'd7;
	localparam logic [3:0] TAG_REPORT_COUNT = 4'd9;

	localparam logic [3:0] TAG_USAGE     = 4'd0;
	localparam logic [3:0] TAG_USAGE_MIN = 4'd1;
	localparam logic [3:0] TAG_USAGE_MAX = 4'd2;

	localparam logic [15:0] MOD_KEY_LO = 16'h00E0;
	localparam logic [15:0] MOD_KEY_HI = 16'h00E7;
	localparam logic [31:0] KEY_SLOT_BITS = 32'd8;

	localparam logic REC_FIELD  = 1'b0;
	localparam logic REC_STATUS = 1'b1;

	typedef enum logic [1:0] {
		P_PREFIX = 2'd0,
		P_LSIZE  = 2'd1,
		P_LBODY  = 2'd2,
		P_SDATA  = 2'd3
	} parse_phase_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_USAGE,
		S_RANGE,
		S_MUL,
		S_ADD,
		S_STATUS
	} seq_state_t;

	typedef struct packed {
		logic        kind;
		logic [15:0] page_id;
		logic [15:0] usage_id;
		logic [31:0] bit_offset;
		logic [31:0] bit_size;
		logic        range_capped;
		logic [1:0]  status;
		logic [15:0] key_slots;
		logic [18:0] key_bits;
		logic        last;
	} rec_t;

	function automatic logic [15:0] key_slot_next(logic [31:0] size, logic [15:0] usage,
			logic [15:0] slots);
		logic modifier;
		begin
			modifier = (usage >= MOD_KEY_LO) && (usage <= MOD_KEY_HI);
			if (size == KEY_SLOT_BITS && !modifier && slots != 16'hFFFF)
				key_slot_next = slots + 16'd1;
			else
				key_slot_next = slots;
		end
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/hrdp_desc_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface hrdp_desc_if;
	logic       valid;
	logic       ready;
	logic [7:0] desc_byte;
	logic       end_of_descriptor;

	modport source (output valid, output desc_byte, output end_of_descriptor, input ready);
	modport sink (input valid, input desc_byte, input end_of_descriptor, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/hrdp_rec_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface hrdp_rec_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [15:0] page_id;
	logic [15:0] usage_id;
	logic [31:0] bit_offset;
	logic [31:0] bit_size;
	logic        range_capped;
	logic [1:0]  status;
	logic [15:0] key_slots;
	logic [18:0] key_bits;
	logic        last;

	modport source (output valid, output kind, output page_id, output usage_id,
		output bit_offset, output bit_size, output range_capped, output status,
		output key_slots, output key_bits, output last, input ready);
	modport sink (input valid, input kind, input page_id, input usage_id,
		input bit_offset, input bit_size, input range_capped, input status,
		input key_slots, input key_bits, input last, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/hid_report_descriptor_parser.sv -----
// HID report descriptor parser. One descriptor byte per transaction, taken
// only while idle, so the next byte waits until the records and offset
// update a byte starts are done. An Input main item walks the stored usages
// in the usage memory (synchronous read, then emit), emits range records,
// and adds size * (count not emitted) to the offset with a multiply-add
// when a range or padding is present. The final byte adds one status
// record. A stalled output holds the sequencer in place. The usage memory
// is not cleared; only entries below the usage count are ever read.
`timescale 1ns / 1ps
`default_nettype none

module hid_report_descriptor_parser
	import hrdp_pkg::*;
#(
	parameter int MAX_USAGES = 16,
	parameter int RANGE_CAP  = 47
) (
	input  wire logic clk,
	input  wire logic arst_n,
	hrdp_desc_if.sink  desc,
	hrdp_rec_if.source rec
);
	localparam int CNT_W = $clog2(MAX_USAGES + 1);
	localparam int IDX_W = (MAX_USAGES > 1) ? $clog2(MAX_USAGES) : 1;
	localparam int CAP   = (MAX_USAGES + RANGE_CAP > 63) ? 63 - MAX_USAGES : RANGE_CAP;

	seq_state_t   state_q, state_d;
	parse_phase_t phase_q, phase_d;
	logic [7:0]   left_q, left_d;
	logic [31:0]  accum_q, accum_d;
	logic [1:0]   bidx_q, bidx_d;
	logic [5:0]   tag_q, tag_d;
	logic [15:0]  page_q, page_d;
	logic [CNT_W-1:0] ucnt_q, ucnt_d;
	logic [CNT_W-1:0] idx_q, idx_d;
	logic [15:0]  rmin_q, rmin_d, rmax_q, rmax_d;
	logic         rvalid_q, rvalid_d;
	logic [31:0]  size_q, size_d, count_q, count_d, offset_q, offset_d;
	logic [15:0]  slot_q, slot_d;
	logic [5:0]   j_q, j_d;
	logic [31:0]  mulop_q, mulop_d, prod_q, prod_d;
	logic         end_q, end_d;
	logic [1:0]   status_q, status_d;

	// byte decode
	parse_phase_t dec_phase;
	logic [7:0]   dec_left;
	logic [31:0]  dec_accum;
	logic [1:0]   dec_bidx;
	logic [5:0]   dec_tag;
	logic         dec_exec;

	logic         accept, push, can_push, mem_we, has_range, capped;
	logic [5:0]   emit;
	logic [15:0]  rdata, range_u, range_sum, slot_new;
	logic [CNT_W-1:0] idx_nx;
	rec_t         rec_d;

	hrdp_usage_mem #(.DEPTH(MAX_USAGES), .AW(IDX_W)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (ucnt_q[IDX_W-1:0]),
		.wdata (dec_accum[15:0]),
		.raddr (idx_q[IDX_W-1:0]),
		.rdata (rdata)
	);

	hrdp_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.rec_in   (rec_d),
		.can_push (can_push),
		.rec      (rec)
	);

	assign desc.ready = (state_q == S_IDLE);
	assign accept     = desc.valid && desc.ready;
	assign has_range  = rvalid_q && (count_q != 32'd0);
	assign emit       = (count_q < 32'(CAP)) ? count_q[5:0] : 6'(CAP);
	assign capped     = (count_q > 32'(CAP));
	assign range_sum  = rmin_q + 16'(j_q);
	assign range_u    = (range_sum > rmax_q) ? rmax_q : range_sum;
	assign idx_nx     = idx_q + CNT_W'(1);

	always_comb begin
		dec_phase = phase_q;
		dec_left  = left_q;
		dec_accum = accum_q;
		dec_bidx  = bidx_q;
		dec_tag   = tag_q;
		dec_exec  = 1'b0;
		unique case (phase_q)
			P_PREFIX: begin
				if (desc.desc_byte == LONG_PREFIX) begin
					dec_phase = P_LSIZE;
				end else begin
					dec_tag   = desc.desc_byte[7:2];
					dec_accum = '0;
					dec_bidx  = '0;
					dec_left  = (desc.desc_byte[1:0] == 2'd3) ? 8'd4 : {6'd0, desc.desc_byte[1:0]};
					if (desc.desc_byte[1:0] == 2'd0)
						dec_exec = 1'b1;
					else
						dec_phase = P_SDATA;
				end
			end
			P_LSIZE: begin
				dec_left  = desc.desc_byte;
				dec_bidx  = '0;
				dec_phase = P_LBODY;
			end
			P_LBODY: begin
				// first body byte is the long item tag
				if (bidx_q == 2'd0)
					dec_bidx = 2'd1;
				else if (left_q != 8'd0)
					dec_left = left_q - 8'd1;
				if (dec_left == 8'd0)
					dec_phase = P_PREFIX;
			end
			P_SDATA: begin
				dec_accum = accum_q | (32'(desc.desc_byte) << {bidx_q, 3'b000});
				dec_bidx  = bidx_q + 2'd1;
				if (left_q != 8'd0)
					dec_left = left_q - 8'd1;
				if (dec_left == 8'd0) begin
					dec_phase = P_PREFIX;
					dec_exec  = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		state_d  = state_q;
		phase_d  = phase_q;
		left_d   = left_q;
		accum_d  = accum_q;
		bidx_d   = bidx_q;
		tag_d    = tag_q;
		page_d   = page_q;
		ucnt_d   = ucnt_q;
		idx_d    = idx_q;
		rmin_d   = rmin_q;
		rmax_d   = rmax_q;
		rvalid_d = rvalid_q;
		size_d   = size_q;
		count_d  = count_q;
		offset_d = offset_q;
		slot_d   = slot_q;
		j_d      = j_q;
		mulop_d  = mulop_q;
		prod_d   = prod_q;
		end_d    = end_q;
		status_d = status_q;
		push     = 1'b0;
		mem_we   = 1'b0;
		slot_new = slot_q;
		rec_d    = '0;

		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					phase_d  = dec_phase;
					left_d   = dec_left;
					accum_d  = dec_accum;
					bidx_d   = dec_bidx;
					tag_d    = dec_tag;
					end_d    = desc.end_of_descriptor;
					status_d = dec_phase;
					state_d  = desc.end_of_descriptor ? S_STATUS : S_IDLE;
					if (dec_exec) begin
						unique case (dec_tag[1:0])
							ITEM_MAIN: begin
								case (dec_tag[5:2]) inside
									TAG_INPUT: begin
										if (ucnt_q != '0) begin
											idx_d   = '0;
											state_d = S_READ;
										end else if (has_range) begin
											j_d     = '0;
											state_d = S_RANGE;
										end else if (!rvalid_q && size_q != 32'd0 &&
												count_q != 32'd0) begin
											mulop_d = count_q;
											state_d = S_MUL;
										end else begin
											rvalid_d = 1'b0;
										end
									end
									TAG_OUTPUT, TAG_COLLECTION, TAG_FEATURE, TAG_END_COLL: begin
										ucnt_d   = '0;
										rvalid_d = 1'b0;
									end
									default: ;
								endcase
							end
							ITEM_GLOBAL: begin
								case (dec_tag[5:2])
									TAG_USAGE_PAGE:   page_d  = dec_accum[15:0];
									TAG_REPORT_SIZE:  size_d  = dec_accum;
									TAG_REPORT_COUNT: count_d = dec_accum;
									default: ;
								endcase
							end
							ITEM_LOCAL: begin
								case (dec_tag[5:2])
									TAG_USAGE: begin
										if (ucnt_q < CNT_W'(MAX_USAGES)) begin
											mem_we = 1'b1;
											ucnt_d = ucnt_q + CNT_W'(1);
										end
									end
									TAG_USAGE_MIN: begin
										rmin_d   = dec_accum[15:0];
										rvalid_d = 1'b1;
									end
									TAG_USAGE_MAX: begin
										rmax_d = dec_accum[15:0];
										if (!rvalid_q) begin
											rmin_d   = dec_accum[15:0];
											rvalid_d = 1'b1;
										end
									end
									default: ;
								endcase
							end
							default: ;
						endcase
					end
				end
			end
			S_READ: state_d = S_USAGE;
			S_USAGE: begin
				if (can_push) begin
					slot_new           = key_slot_next(size_q, rdata, slot_q);
					push               = 1'b1;
					rec_d.kind         = REC_FIELD;
					rec_d.page_id      = page_q;
					rec_d.usage_id     = rdata;
					rec_d.bit_offset   = offset_q;
					rec_d.bit_size     = size_q;
					rec_d.key_slots    = slot_new;
					rec_d.key_bits     = {slot_new, 3'b000};
					rec_d.last         = (idx_nx == ucnt_q) && !has_range && !end_q;
					slot_d             = slot_new;
					offset_d           = offset_q + size_q;
					idx_d              = idx_nx;
					if (idx_nx != ucnt_q) begin
						state_d = S_READ;
					end else if (has_range) begin
						j_d     = '0;
						state_d = S_RANGE;
					end else begin
						ucnt_d   = '0;
						rvalid_d = 1'b0;
						state_d  = end_q ? S_STATUS : S_IDLE;
					end
				end
			end
			S_RANGE: begin
				if (can_push) begin
					slot_new           = key_slot_next(size_q, range_u, slot_q);
					push               = 1'b1;
					rec_d.kind         = REC_FIELD;
					rec_d.page_id      = page_q;
					rec_d.usage_id     = range_u;
					rec_d.bit_offset   = offset_q;
					rec_d.bit_size     = size_q;
					rec_d.range_capped = capped;
					rec_d.key_slots    = slot_new;
					rec_d.key_bits     = {slot_new, 3'b000};
					rec_d.last         = (j_q + 6'd1 == emit) && !end_q;
					slot_d             = slot_new;
					offset_d           = offset_q + size_q;
					j_d                = j_q + 6'd1;
					if (j_q + 6'd1 == emit) begin
						// dropped records still take their space
						mulop_d = count_q - 32'(emit);
						state_d = S_MUL;
					end
				end
			end
			S_MUL: begin
				prod_d  = size_q * mulop_q;
				state_d = S_ADD;
			end
			S_ADD: begin
				offset_d = offset_q + prod_q;
				ucnt_d   = '0;
				rvalid_d = 1'b0;
				state_d  = end_q ? S_STATUS : S_IDLE;
			end
			S_STATUS: begin
				if (can_push) begin
					push            = 1'b1;
					rec_d.kind      = REC_STATUS;
					rec_d.status    = status_q;
					rec_d.key_slots = slot_q;
					rec_d.key_bits  = {slot_q, 3'b000};
					rec_d.last      = 1'b1;
					phase_d  = P_PREFIX;
					left_d   = '0;
					accum_d  = '0;
					bidx_d   = '0;
					tag_d    = '0;
					page_d   = '0;
					ucnt_d   = '0;
					rmin_d   = '0;
					rmax_d   = '0;
					rvalid_d = 1'b0;
					size_d   = '0;
					count_d  = '0;
					offset_d = '0;
					slot_d   = '0;
					end_d    = 1'b0;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			phase_q  <= P_PREFIX;
			left_q   <= '0;
			accum_q  <= '0;
			bidx_q   <= '0;
			tag_q    <= '0;
			page_q   <= '0;
			ucnt_q   <= '0;
			idx_q    <= '0;
			rmin_q   <= '0;
			rmax_q   <= '0;
			rvalid_q <= 1'b0;
			size_q   <= '0;
			count_q  <= '0;
			offset_q <= '0;
			slot_q   <= '0;
			j_q      <= '0;
			end_q    <= 1'b0;
			status_q <= '0;
		end else begin
			state_q  <= state_d;
			phase_q  <= phase_d;
			left_q   <= left_d;
			accum_q  <= accum_d;
			bidx_q   <= bidx_d;
			tag_q    <= tag_d;
			page_q   <= page_d;
			ucnt_q   <= ucnt_d;
			idx_q    <= idx_d;
			rmin_q   <= rmin_d;
			rmax_q   <= rmax_d;
			rvalid_q <= rvalid_d;
			size_q   <= size_d;
			count_q  <= count_d;
			offset_q <= offset_d;
			slot_q   <= slot_d;
			j_q      <= j_d;
			end_q    <= end_d;
			status_q <= status_d;
		end
	end

	always_ff @(posedge clk) begin
		mulop_q <= mulop_d;
		prod_q  <= prod_d;
	end

`ifndef SYNTHESIS
	a_ucnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ucnt_q <= CNT_W'(MAX_USAGES))
		else $error("usage count past memory depth");
	a_range_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RANGE |-> j_q < emit)
		else $error("range index past emit count");
	a_status_reset: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_STATUS && can_push) |=> (offset_q == 32'd0 && slot_q == 16'd0 &&
			ucnt_q == '0 && state_q == S_IDLE))
		else $error("state not cleared after status record");
	a_usage_read: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_USAGE |-> (idx_q < ucnt_q && $past(state_q) != S_IDLE))
		else $error("usage read outside stored entries");
`endif
endmodule

`default_nettype wire

// ----- hw/rtl/hrdp_usage_mem.sv -----
`timescale 1ns / 1ps
`default_nettype none

module hrdp_usage_mem #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [15:0]   wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [15:0]   rdata
);
	logic [15:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end
endmodule

`default_nettype wire

// ----- hw/rtl/hrdp_out_stage.sv -----
`timescale 1ns / 1ps
`default_nettype none

module hrdp_out_stage
	import hrdp_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire rec_t rec_in,
	output logic      can_push,
	hrdp_rec_if.source rec
);
	logic valid_q;
	rec_t data_q;

	assign can_push = !valid_q || rec.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (can_push)
			valid_q <= push;
	end

	always_ff @(posedge clk) begin
		if (can_push && push)
			data_q <= rec_in;
	end

	assign rec.valid        = valid_q;
	assign rec.kind         = data_q.kind;
	assign rec.page_id      = data_q.page_id;
	assign rec.usage_id     = data_q.usage_id;
	assign rec.bit_offset   = data_q.bit_offset;
	assign rec.bit_size     = data_q.bit_size;
	assign rec.range_capped = data_q.range_capped;
	assign rec.status       = data_q.status;
	assign rec.key_slots    = data_q.key_slots;
	assign rec.key_bits     = data_q.key_bits;
	assign rec.last         = data_q.last;
endmodule

`default_nettype wire

// ----- tb/tb_hid_report_descriptor_parser.sv -----
`timescale 1ns / 1ps

module tb_hid_report_descriptor_parser;
	import hrdp_pkg::*;

	localparam int NUM_USAGES = 16;
	localparam int CAP_RANGE  = 47;
	localparam int N_ITEMS    = 350;

	logic clk;
	logic arst_n;

	hrdp_desc_if desc_ch();
	hrdp_rec_if  rec_ch();

	hid_report_descriptor_parser #(
		.MAX_USAGES(NUM_USAGES),
		.RANGE_CAP (CAP_RANGE)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.desc  (desc_ch.sink),
		.rec   (rec_ch.source)
	);

	typedef struct {
		logic [7:0] b;
		logic       eod;
		logic       has_exp;
		rec_t       exp;
	} stim_row_t;

	// parser mirror
	parse_phase_t m_phase;
	logic [7:0]   m_left;
	logic [31:0]  m_accum;
	logic [1:0]   m_idx;
	logic [5:0]   m_tt;
	logic [15:0]  m_page;
	logic [15:0]  m_usages [NUM_USAGES];
	int           m_ucount;
	logic [15:0]  m_rmin, m_rmax;
	logic         m_rvalid;
	logic [31:0]  m_size, m_count, m_offset;
	logic [15:0]  m_slots;

	rec_t expected_recs[$];
	rec_t burst[$];
	int   n_errors;
	int   n_sent;
	bit   feed_done;

	always #5 clk = ~clk;

	task automatic report(input string msg);
		$display("ERROR @%0t: %s", $time, msg);
		n_errors++;
	endtask

	function automatic void mirror_reset();
		m_phase = P_PREFIX;
		m_left = '0; m_accum = '0; m_idx = '0; m_tt = '0; m_page = '0;
		m_ucount = 0; m_rmin = '0; m_rmax = '0; m_rvalid = 1'b0;
		m_size = '0; m_count = '0; m_offset = '0; m_slots = '0;
	endfunction

	function automatic void push_rec(input logic kind, input logic [15:0] usage,
			input logic capped, input logic [1:0] st);
		rec_t r;
		r.kind = kind;
		r.page_id = kind ? 16'd0 : m_page;
		r.usage_id = kind ? 16'd0 : usage;
		r.bit_offset = kind ? 32'd0 : m_offset;
		r.bit_size = kind ? 32'd0 : m_size;
		r.range_capped = capped;
		r.status = st;
		r.key_slots = m_slots;
		r.key_bits = {m_slots, 3'b000};
		r.last = 1'b0;
		burst.push_back(r);
	endfunction

	function automatic void emit_field(input logic [15:0] usage, input logic capped);
		if (m_size == 32'd8 && !(usage >= 16'hE0 && usage <= 16'hE7) && m_slots != 16'hFFFF)
			m_slots++;
		push_rec(REC_FIELD, usage, capped, 2'd0);
		m_offset += m_size;
	endfunction

	function automatic void run_item();
		logic [1:0]  itype;
		logic [3:0]  itag;
		int unsigned cap, emit;
		logic [15:0] u;
		itype = m_tt[1:0];
		itag = m_tt[5:2];
		cap = CAP_RANGE;
		if (NUM_USAGES + cap > 63) cap = (NUM_USAGES >= 63) ? 0 : 63 - NUM_USAGES;
		if (itype == ITEM_MAIN) begin
			if (itag == TAG_INPUT) begin
				for (int i = 0; i < m_ucount; i++)
					emit_field(m_usages[i], 1'b0);
				if (m_rvalid && m_count != 0) begin
					emit = (m_count < cap) ? m_count : cap;
					for (int unsigned j = 0; j < emit; j++) begin
						u = m_rmin + 16'(j);
						if (u > m_rmax) u = m_rmax;
						emit_field(u, m_count > cap);
					end
					m_offset += m_size * (m_count - emit);
				end else if (m_ucount == 0 && !m_rvalid && m_size != 0 && m_count != 0) begin
					m_offset += m_size * m_count;
				end
				m_ucount = 0; m_rvalid = 1'b0;
			end else if (itag inside {TAG_OUTPUT, TAG_COLLECTION, TAG_FEATURE, TAG_END_COLL}) begin
				m_ucount = 0; m_rvalid = 1'b0;
			end
		end else if (itype == ITEM_GLOBAL) begin
			if (itag == TAG_USAGE_PAGE) m_page = m_accum[15:0];
			else if (itag == TAG_REPORT_SIZE) m_size = m_accum;
			else if (itag == TAG_REPORT_COUNT) m_count = m_accum;
		end else if (itype == ITEM_LOCAL) begin
			if (itag == TAG_USAGE) begin
				if (m_ucount < NUM_USAGES) m_usages[m_ucount++] = m_accum[15:0];
			end else if (itag == TAG_USAGE_MIN) begin
				m_rmin = m_accum[15:0]; m_rvalid = 1'b1;
			end else if (itag == TAG_USAGE_MAX) begin
				m_rmax = m_accum[15:0];
				if (!m_rvalid) begin
					m_rmin = m_accum[15:0]; m_rvalid = 1'b1;
				end
			end
		end
	endfunction

	// fills burst with the records this byte produces, last flag set on the final one
	function automatic void predict_byte(input logic [7:0] b, input logic eod);
		logic [2:0] sz;
		burst.delete();
		case (m_phase)
			P_PREFIX: begin
				if (b == LONG_PREFIX) begin
					m_phase = P_LSIZE;
				end else begin
					sz = (b[1:0] == 2'd3) ? 3'd4 : {1'b0, b[1:0]};
					m_tt = b[7:2]; m_accum = '0; m_idx = '0; m_left = 8'(sz);
					if (sz == 0) run_item();
					else m_phase = P_SDATA;
				end
			end
			P_LSIZE: begin
				m_left = b; m_idx = '0; m_phase = P_LBODY;
			end
			P_LBODY: begin
				if (m_idx == 0) m_idx = 2'd1;
				else if (m_left != 0) m_left--;
				if (m_left == 0) m_phase = P_PREFIX;
			end
			default: begin
				m_accum |= 32'(b) << (m_idx * 8);
				m_idx++;
				if (m_left != 0) m_left--;
				if (m_left == 0) begin
					m_phase = P_PREFIX;
					run_item();
				end
			end
		endcase
		if (eod) begin
			push_rec(REC_STATUS, 16'd0, 1'b0, 2'(m_phase));
			mirror_reset();
		end
		if (burst.size() > 0) burst[burst.size()-1].last = 1'b1;
	endfunction

	// valid stays high after the transaction unless an idle gap follows
	task automatic send_byte(input logic [7:0] b, input logic eod, input logic has_exp,
			input rec_t exp);
		int gap;
		gap = $urandom_range(0, 14);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			desc_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		desc_ch.valid <= 1'b1;
		desc_ch.desc_byte <= b;
		desc_ch.end_of_descriptor <= eod;
		predict_byte(b, eod);
		if (has_exp && (burst.size() != 1 || burst[0] !== exp))
			report($sformatf("table row 0x%02h disagrees with predictor", b));
		foreach (burst[i]) expected_recs.push_back(burst[i]);
		@(posedge clk);
		while (!desc_ch.ready) @(posedge clk);
		n_sent++;
	endtask

	// drop valid and hold off until everything expected has come back
	task automatic drain();
		desc_ch.valid <= 1'b0;
		do @(posedge clk); while (expected_recs.size() != 0);
	endtask

	task automatic send_item(input logic [7:0] prefix, input logic [31:0] data,
			input logic eod_on_last);
		int n;
		rec_t dummy;
		n = (prefix[1:0] == 2'd3) ? 4 : prefix[1:0];
		dummy = '0;
		send_byte(prefix, (n == 0) && eod_on_last, 1'b0, dummy);
		for (int i = 0; i < n; i++)
			send_byte(data[i*8 +: 8], (i == n - 1) && eod_on_last, 1'b0, dummy);
	endtask

	// receiver with random backpressure
	initial begin
		rec_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			int stall;
			stall = $urandom_range(0, 14);
			if ($urandom_range(0, 3) == 0) stall = 0;
			if (stall > 0) begin
				rec_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rec_ch.ready <= 1'b1;
			@(posedge clk);
			while (!rec_ch.valid) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n && rec_ch.valid && rec_ch.ready) begin
			rec_t got, want;
			got.kind = rec_ch.kind; got.page_id = rec_ch.page_id;
			got.usage_id = rec_ch.usage_id; got.bit_offset = rec_ch.bit_offset;
			got.bit_size = rec_ch.bit_size; got.range_capped = rec_ch.range_capped;
			got.status = rec_ch.status; got.key_slots = rec_ch.key_slots;
			got.key_bits = rec_ch.key_bits; got.last = rec_ch.last;
			if (expected_recs.size() == 0) begin
				report("record with nothing expected");
			end else begin
				want = expected_recs.pop_front();
				if (got.kind !== want.kind) report($sformatf("kind %0d exp %0d",
					got.kind, want.kind));
				if (got.page_id !== want.page_id) report($sformatf("page %h exp %h",
					got.page_id, want.page_id));
				if (got.usage_id !== want.usage_id) report($sformatf("usage %h exp %h",
					got.usage_id, want.usage_id));
				if (got.bit_offset !== want.bit_offset) report($sformatf("offset %h exp %h",
					got.bit_offset, want.bit_offset));
				if (got.bit_size !== want.bit_size) report($sformatf("size %h exp %h",
					got.bit_size, want.bit_size));
				if (got.range_capped !== want.range_capped) report($sformatf(
					"capped %b exp %b", got.range_capped, want.range_capped));
				if (got.status !== want.status) report($sformatf("status %0d exp %0d",
					got.status, want.status));
				if (got.key_slots !== want.key_slots) report($sformatf("slots %0d exp %0d",
					got.key_slots, want.key_slots));
				if (got.key_bits !== want.key_bits) report($sformatf("kbits %0d exp %0d",
					got.key_bits, want.key_bits));
				if (got.last !== want.last) report($sformatf("last %b exp %b",
					got.last, want.last));
			end
		end
	end

	function automatic logic [7:0] mk_prefix(input logic [1:0] itype, input logic [3:0] itag,
			input logic [1:0] sz);
		return {itag, itype, sz};
	endfunction

	function automatic rec_t status_rec(input logic [1:0] st);
		rec_t r;
		r = '0;
		r.kind = REC_STATUS; r.status = st; r.last = 1'b1;
		return r;
	endfunction

	// random well-formed item with occasional noise
	task automatic random_item(input logic eod);
		logic [31:0] d;
		logic [1:0]  sz;
		int sel;
		d = $urandom();
		sz = 2'($urandom_range(0, 3));
		sel = $urandom_range(0, 99);
		if (sel < 12) begin
			send_item(mk_prefix(ITEM_GLOBAL, TAG_REPORT_SIZE, 2'd1),
				($urandom_range(0, 1) ? 32'd8 : $urandom_range(0, 16)), eod);
		end else if (sel < 24) begin
			send_item(mk_prefix(ITEM_GLOBAL, TAG_REPORT_COUNT, 2'd1),
				$urandom_range(0, 70), eod);
		end else if (sel < 32) begin
			send_item(mk_prefix(ITEM_GLOBAL, TAG_USAGE_PAGE, sz), d, eod);
		end else if (sel < 50) begin
			send_item(mk_prefix(ITEM_LOCAL, TAG_USAGE, sz),
				($urandom_range(0, 1) ? $urandom_range(16'hDC, 16'hEA) : d), eod);
		end else if (sel < 58) begin
			send_item(mk_prefix(ITEM_LOCAL, TAG_USAGE_MIN, sz), d, eod);
		end else if (sel < 66) begin
			send_item(mk_prefix(ITEM_LOCAL, TAG_USAGE_MAX, sz), d, eod);
		end else if (sel < 80) begin
			send_item(mk_prefix(ITEM_MAIN, TAG_INPUT, sz), d, eod);
		end else if (sel < 86) begin
			send_item(mk_prefix(ITEM_MAIN, 4'($urandom_range(9, 12)), sz), d, eod);
		end else if (sel < 92) begin
			rec_t z;
			int nb;
			z = '0;
			nb = $urandom_range(0, 6);
			send_byte(LONG_PREFIX, 1'b0, 1'b0, z);
			send_byte(8'($urandom_range(0, 4)), 1'b0, 1'b0, z);
			for (int i = 0; i < nb; i++)
				send_byte(8'($urandom()), 1'b0, 1'b0, z);
			send_byte(8'($urandom()), eod, 1'b0, z);
		end else begin
			rec_t z;
			z = '0;
			send_byte(8'($urandom()), eod, 1'b0, z);
		end
	endtask

	initial begin
		stim_row_t table_rows[$];
		stim_row_t row;
		rec_t z;
		bit paused;
		clk = 1'b0;
		arst_n = 1'b0;
		n_errors = 0;
		n_sent = 0;
		feed_done = 0;
		paused = 1'b0;
		desc_ch.valid = 1'b0;
		desc_ch.desc_byte = '0;
		desc_ch.end_of_descriptor = 1'b0;
		mirror_reset();
		z = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		table_rows = '{
			'{8'h00, 1'b1, 1'b1, status_rec(2'd0)},
			'{8'hFE, 1'b1, 1'b1, status_rec(2'd1)},
			'{8'hFE, 1'b0, 1'b0, z}, '{8'h03, 1'b1, 1'b1, status_rec(2'd2)},
			'{8'h07, 1'b1, 1'b1, status_rec(2'd3)},
			'{8'h05, 1'b0, 1'b0, z}, '{8'h07, 1'b0, 1'b0, z},
			'{8'h75, 1'b0, 1'b0, z}, '{8'h08, 1'b0, 1'b0, z},
			'{8'h95, 1'b0, 1'b0, z}, '{8'h46, 1'b0, 1'b0, z},
			'{8'h19, 1'b0, 1'b0, z}, '{8'hE0, 1'b0, 1'b0, z},
			'{8'h29, 1'b0, 1'b0, z}, '{8'hE3, 1'b0, 1'b0, z},
			'{8'h09, 1'b0, 1'b0, z}, '{8'h04, 1'b0, 1'b0, z},
			'{8'h81, 1'b0, 1'b0, z}, '{8'h02, 1'b0, 1'b0, z},
			'{8'h0F, 1'b0, 1'b0, z}, '{8'hFF, 1'b0, 1'b0, z},
			'{8'hFF, 1'b0, 1'b0, z}, '{8'hFF, 1'b0, 1'b0, z},
			'{8'hFF, 1'b0, 1'b0, z}, '{8'hFC, 1'b1, 1'b0, z}
		};
		foreach (table_rows[i]) begin
			row = table_rows[i];
			send_byte(row.b, row.eod, row.has_exp, row.exp);
		end

		// full usage list plus range max only, then Input
		send_item(mk_prefix(ITEM_GLOBAL, TAG_REPORT_COUNT, 2'd1), 32'd60, 1'b0);
		for (int i = 0; i < 18; i++)
			send_item(mk_prefix(ITEM_LOCAL, TAG_USAGE, 2'd2), 16'hE0 + i, 1'b0);
		send_item(mk_prefix(ITEM_LOCAL, TAG_USAGE_MAX, 2'd2), 32'hFFFE, 1'b0);
		send_item(mk_prefix(ITEM_MAIN, TAG_INPUT, 2'd0), 32'd0, 1'b0);
		send_item(mk_prefix(ITEM_GLOBAL, TAG_REPORT_SIZE, 2'd3), 32'hFFFF_FFFF, 1'b0);
		send_item(mk_prefix(ITEM_MAIN, TAG_INPUT, 2'd0), 32'd0, 1'b1);

		// hold off until everything drains
		drain();

		while (n_sent < N_ITEMS - 1) begin
			random_item($urandom_range(0, 19) == 0);
			if (!paused && n_sent >= N_ITEMS / 2) begin
				paused = 1'b1;
				drain();
			end
		end
		send_byte(8'h00, 1'b1, 1'b0, z);
		desc_ch.valid <= 1'b0;
		feed_done = 1;
	end

	initial begin
		wait (feed_done);
		while (expected_recs.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (n_errors == 0 && expected_recs.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#20ms;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
